### src/lmob_pkg.sv
// shared types, codes and constants of the led on/off bank
`default_nettype none
package lmob_pkg;

    // default sizes of the scan matrix
    localparam int DEF_MAX_ROWS   = 11;
    localparam int DEF_MAX_COLS   = 18;
    localparam int DEF_BANK_BYTES = 33;

    // fixed field widths
    localparam int ROWS_W     = 4;
    localparam int COLS_W     = 5;
    localparam int ROWS_SAT_W = 5;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int SUM_W      = 10;
    localparam int BYTES_PER_ROW = 3;

    // reset values of the configuration registers
    localparam logic [ROWS_W-1:0] RESET_ROWS = 4'd6;
    localparam logic [COLS_W-1:0] RESET_COLS = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    // command codes
    localparam logic [1:0] CMD_GET  = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_TEST = 2'd2;

    // test mode request codes
    localparam logic [1:0] REQ_NORMAL  = 2'd0;
    localparam logic [1:0] REQ_ALL_ON  = 2'd1;
    localparam logic [1:0] REQ_ALL_OFF = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_RANGE   = 2'd1;
    localparam logic [1:0] STAT_BLOCKED = 2'd2;

    // lamp test fill patterns
    localparam logic [7:0] FILL_ON  = 8'hFF;
    localparam logic [7:0] FILL_OFF = 8'h00;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_ALL_ON  = 2'd1,
        MODE_ALL_OFF = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic slot_free;
    } dp_stat_t;

endpackage
`default_nettype wire

### src/led_matrix_onoff_bank_with_lamp_test_unit.sv
// Top level of the led on/off bank with lamp test.
//
// Input channel (in_valid/in_ready) carries one transaction: cmd, led_index,
// led_value and test_mode_request. Get returns the led bit, set writes it,
// test requests switch between normal, all-on and all-off lamp test.
// Output channel (out_valid/out_ready) returns led_state and status for every
// input transaction, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes rows_in_use
// (index 0) and cols_in_use (index 1); cfg_ready is always high.
// Sequence: a taken transaction passes the divider (ST_DIV), the bank memory
// read (ST_ADDR) and the execute step (ST_EXEC); the next transaction is taken
// only once the controller is back in ST_IDLE. The divider splits the index
// into row and column, two quotient bits per step.
// A finished result waits in the output register; the next input transaction
// is taken meanwhile, and its execute step holds until out_ready drains it.
// Reset: bank reads all zero (per-byte valid bits clear at once), normal mode,
// rows_in_use 6, cols_in_use 16; no clearing pass is needed.
`default_nettype none
module led_matrix_onoff_bank_with_lamp_test_unit #(
    parameter int MAX_ROWS   = lmob_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = lmob_pkg::DEF_MAX_COLS,
    parameter int BANK_BYTES = lmob_pkg::DEF_BANK_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        cmd,
    input  wire logic [lmob_pkg::IDX_W-1:0]        led_index,
    input  wire logic                              led_value,
    input  wire logic [1:0]                        test_mode_request,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   led_state,
    output logic [1:0]                             status,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lmob_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lmob_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lmob_pkg::ctrl_cmd_t ctrl;
    lmob_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    lmob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    lmob_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .BANK_BYTES (BANK_BYTES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .stat              (stat),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .led_index         (led_index),
        .led_value         (led_value),
        .test_mode_request (test_mode_request),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .led_state         (led_state),
        .status            (status)
    );

endmodule
`default_nettype wire

### src/lmob_div.sv
// iterative divider, two quotient bits per cycle
`default_nettype none
module lmob_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lmob_pkg::IDX_W-1:0]    dividend,
    input  wire logic [lmob_pkg::COLS_W-1:0]   divisor,
    output logic                               done,
    output logic [lmob_pkg::IDX_W-1:0]         quotient,
    output logic [lmob_pkg::COLS_W-1:0]        remainder
);

    localparam int STEPS = lmob_pkg::IDX_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int CW    = lmob_pkg::COLS_W;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [lmob_pkg::IDX_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     div_reg;

    logic [CW:0]   t1, t2;
    logic [CW-1:0] r1, r2;
    logic          b1, b2;

    // two restoring steps
    always_comb
    begin
        t1 = {rem_reg, quo_reg[lmob_pkg::IDX_W-1]};
        b1 = (t1 >= {1'b0, div_reg});
        r1 = b1 ? CW'(t1 - {1'b0, div_reg}) : t1[CW-1:0];
        t2 = {r1, quo_reg[lmob_pkg::IDX_W-2]};
        b2 = (t2 >= {1'b0, div_reg});
        r2 = b2 ? CW'(t2 - {1'b0, div_reg}) : t2[CW-1:0];
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[lmob_pkg::IDX_W-3:0], b1, b2};
            rem_next = r2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done      = busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

### src/lmob_ctrl.sv
// controller state machine that sequences one item at a time
`default_nettype none
module lmob_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lmob_pkg::dp_stat_t stat,
    output lmob_pkg::ctrl_cmd_t     ctrl
);

    lmob_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmob_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            lmob_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = lmob_pkg::ST_DIV;
                end
            end
            lmob_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = lmob_pkg::ST_ADDR;
                end
            end
            lmob_pkg::ST_ADDR:
            begin
                ctrl.rd    = 1'b1;
                state_next = lmob_pkg::ST_EXEC;
            end
            lmob_pkg::ST_EXEC:
            begin
                // hold until the result register can take the result
                if (stat.slot_free)
                begin
                    ctrl.exec  = 1'b1;
                    state_next = lmob_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmob_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/lmob_dp.sv
// datapath: config registers, divider, bank memory, mode and result register
`default_nettype none
module lmob_dp #(
    parameter int MAX_ROWS   = lmob_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = lmob_pkg::DEF_MAX_COLS,
    parameter int BANK_BYTES = lmob_pkg::DEF_BANK_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lmob_pkg::ctrl_cmd_t               ctrl,
    output lmob_pkg::dp_stat_t                     stat,
    input  wire logic                              cfg_valid,
    input  wire logic [lmob_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lmob_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [1:0]                        cmd,
    input  wire logic [lmob_pkg::IDX_W-1:0]        led_index,
    input  wire logic                              led_value,
    input  wire logic [1:0]                        test_mode_request,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   led_state,
    output logic [1:0]                             status
);

    localparam int ADDR_W = $clog2(BANK_BYTES);
    localparam int SW     = lmob_pkg::SUM_W;

    // configuration registers
    logic [lmob_pkg::ROWS_W-1:0] rows_reg;
    logic [lmob_pkg::COLS_W-1:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= lmob_pkg::RESET_ROWS;
            cols_reg <= lmob_pkg::RESET_COLS;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lmob_pkg::REG_ROWS)
            begin
                rows_reg <= cfg_data[lmob_pkg::ROWS_W-1:0];
            end
            else if (cfg_index == lmob_pkg::REG_COLS)
            begin
                cols_reg <= cfg_data;
            end
        end
    end

    // saturate to the matrix size
    logic [lmob_pkg::ROWS_SAT_W-1:0] rows_ext, rows_sat;
    logic [lmob_pkg::COLS_W-1:0]     cols_sat;

    always_comb
    begin
        rows_ext = {1'b0, rows_reg};
        rows_sat = (rows_ext > lmob_pkg::ROWS_SAT_W'(MAX_ROWS)) ?
                   lmob_pkg::ROWS_SAT_W'(MAX_ROWS) : rows_ext;
        cols_sat = (cols_reg > lmob_pkg::COLS_W'(MAX_COLS)) ?
                   lmob_pkg::COLS_W'(MAX_COLS) : cols_reg;
    end

    // item capture
    logic [1:0] cmd_reg, req_reg;
    logic       val_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            req_reg <= test_mode_request;
            val_reg <= led_value;
        end
    end

    // row and column from the led index
    logic [lmob_pkg::IDX_W-1:0]  quo;
    logic [lmob_pkg::COLS_W-1:0] rem;
    logic                        div_done;

    lmob_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.load),
        .dividend  (led_index),
        .divisor   (cols_sat),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // byte address and range check
    logic [SW-1:0] byte_sum;
    logic          in_rows, addr_ok;

    always_comb
    begin
        byte_sum = {1'b0, quo, 1'b0} + {2'b00, quo} + {8'd0, rem[4:3]};
        in_rows  = (rows_sat != '0) && (cols_sat != '0) &&
                   (quo < {3'b000, rows_sat});
        addr_ok  = in_rows && (byte_sum < SW'(BANK_BYTES));
    end

    logic              ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            ok_reg   <= addr_ok;
            addr_reg <= byte_sum[ADDR_W-1:0];
            bit_reg  <= rem[2:0];
        end
    end

    // bank memory with per-byte valid bits, unwritten bytes read zero
    logic [7:0]            bank_mem [BANK_BYTES];
    logic [7:0]            rd_data_reg;
    logic                  rd_vld_reg;
    logic [BANK_BYTES-1:0] vld_reg, vld_next;
    logic                  mem_we;
    logic [7:0]            wr_data;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd && addr_ok)
        begin
            rd_data_reg <= bank_mem[byte_sum[ADDR_W-1:0]];
        end
        if (mem_we)
        begin
            bank_mem[addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (ctrl.rd)
            begin
                rd_vld_reg <= addr_ok && vld_reg[byte_sum[ADDR_W-1:0]];
            end
        end
    end

    // execute: result, bank write and lamp test mode
    lmob_pkg::mode_t mode_reg, mode_next;
    logic [7:0] phys_byte, fill_byte, view_byte;
    logic       state_bit;
    logic [1:0] stat_code;
    logic       res_state;

    always_comb
    begin
        phys_byte = rd_vld_reg ? rd_data_reg : 8'h00;
        fill_byte = (mode_reg == lmob_pkg::MODE_ALL_ON) ?
                    lmob_pkg::FILL_ON : lmob_pkg::FILL_OFF;
        view_byte = (mode_reg != lmob_pkg::MODE_NORMAL) ? fill_byte : phys_byte;
        state_bit = view_byte[bit_reg];
        wr_data   = phys_byte;
        wr_data[bit_reg] = val_reg;

        mem_we    = 1'b0;
        vld_next  = vld_reg;
        mode_next = mode_reg;
        stat_code = lmob_pkg::STAT_DONE;
        res_state = 1'b0;

        unique case (cmd_reg)
            lmob_pkg::CMD_GET:
            begin
                if (ok_reg)
                begin
                    res_state = state_bit;
                end
                else
                begin
                    stat_code = lmob_pkg::STAT_RANGE;
                end
            end
            lmob_pkg::CMD_SET:
            begin
                if (!ok_reg)
                begin
                    stat_code = lmob_pkg::STAT_RANGE;
                end
                else if (mode_reg != lmob_pkg::MODE_NORMAL)
                begin
                    stat_code = lmob_pkg::STAT_BLOCKED;
                end
                else
                begin
                    mem_we = ctrl.exec;
                    if (ctrl.exec)
                    begin
                        vld_next[addr_reg] = 1'b1;
                    end
                end
            end
            lmob_pkg::CMD_TEST:
            begin
                // the bank is frozen during lamp test, so leaving restores it
                if (ctrl.exec)
                begin
                    unique case (req_reg)
                        lmob_pkg::REQ_NORMAL:  mode_next = lmob_pkg::MODE_NORMAL;
                        lmob_pkg::REQ_ALL_ON:  mode_next = lmob_pkg::MODE_ALL_ON;
                        lmob_pkg::REQ_ALL_OFF: mode_next = lmob_pkg::MODE_ALL_OFF;
                        default:               mode_next = mode_reg;
                    endcase
                end
            end
            default:
            begin
                stat_code = lmob_pkg::STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lmob_pkg::MODE_NORMAL;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // result register
    logic       out_valid_reg, out_valid_next;
    logic       led_state_reg;
    logic [1:0] status_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            led_state_reg <= res_state;
            status_reg    <= stat_code;
        end
    end

    assign stat      = '{div_done: div_done, slot_free: !out_valid_reg || out_ready};
    assign out_valid = out_valid_reg;
    assign led_state = led_state_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

### src/lmob_checker.sv
// port-level checker of the led on/off bank and its bind
`default_nettype none
module lmob_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       led_state,
    input wire logic [1:0] status
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(led_state))
    else $error("stalled result changed");

    // status is one of the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == lmob_pkg::STAT_DONE) || (status == lmob_pkg::STAT_RANGE)
                      || (status == lmob_pkg::STAT_BLOCKED))
    else $error("undefined status code");

    // an error result never reports a lit led
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != lmob_pkg::STAT_DONE) |-> !led_state)
    else $error("led_state set on error status");

    // one item at a time: busy right after a transaction is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

endmodule

bind led_matrix_onoff_bank_with_lamp_test_unit lmob_checker u_lmob_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led_state (led_state),
    .status    (status)
);
`default_nettype wire

### bench/led_matrix_onoff_bank_with_lamp_test_unit_tb.sv
// testbench for the led on/off bank with lamp test: directed and random transactions
`default_nettype none
module led_matrix_onoff_bank_with_lamp_test_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // codes outside the defined sets
    localparam logic [1:0]                     CMD_NONE    = 2'd3;
    localparam logic [1:0]                     REQ_UNKNOWN = 2'd3;
    localparam logic [lmob_pkg::CFG_IDX_W-1:0] REG_NONE    = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic       led_state;
        logic [1:0] status;
    } led_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [1:0]                      cmd;
    logic [lmob_pkg::IDX_W-1:0]      led_index;
    logic                            led_value;
    logic [1:0]                      test_mode_request;
    logic                            out_valid;
    logic                            out_ready;
    logic                            led_state;
    logic [1:0]                      status;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lmob_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lmob_pkg::CFG_DATA_W-1:0] cfg_data;

    // local copy of the bank, the lamp test state and the registers
    logic [7:0]     bank_copy [lmob_pkg::DEF_BANK_BYTES];
    logic [7:0]     saved_copy [lmob_pkg::DEF_BANK_BYTES];
    lmob_pkg::mode_t mode_copy;
    logic [lmob_pkg::ROWS_W-1:0] rows_copy;
    logic [lmob_pkg::COLS_W-1:0] cols_copy;

    led_result_t expected_results [$];
    int          mismatch_count;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_left;

    led_matrix_onoff_bank_with_lamp_test_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .led_index         (led_index),
        .led_value         (led_value),
        .test_mode_request (test_mode_request),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .led_state         (led_state),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("led_matrix_onoff_bank_with_lamp_test_unit_tb failed");
            $finish;
        end
    end

    // receiver readiness: long hold first, else random idling
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready = 1'b0;
            rx_hold_left--;
        end
        else
            out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        led_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: led_state %0d status %0d",
                       led_state, status);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (led_state !== want.led_state)
                begin
                    $error("led_state: expected %0d, actual %0d", want.led_state, led_state);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    // number of addressable leds after saturation
    function automatic int led_count();
        int rows_eff;
        int cols_eff;
        rows_eff = (rows_copy > lmob_pkg::DEF_MAX_ROWS) ? lmob_pkg::DEF_MAX_ROWS : rows_copy;
        cols_eff = (cols_copy > lmob_pkg::DEF_MAX_COLS) ? lmob_pkg::DEF_MAX_COLS : cols_copy;
        return rows_eff * cols_eff;
    endfunction

    // map a linear index to bank byte and bit, 0 when no led is addressed
    function automatic logic find_led(input logic [lmob_pkg::IDX_W-1:0] idx,
                                      output int byte_sel, output int bit_sel);
        int cols_eff;
        int col;
        byte_sel = 0;
        bit_sel  = 0;
        cols_eff = (cols_copy > lmob_pkg::DEF_MAX_COLS) ? lmob_pkg::DEF_MAX_COLS : cols_copy;
        if (led_count() == 0 || idx >= led_count())
            return 1'b0;
        col = idx % cols_eff;
        byte_sel = (idx / cols_eff) * lmob_pkg::BYTES_PER_ROW + col / 8;
        bit_sel  = col % 8;
        return (byte_sel < lmob_pkg::DEF_BANK_BYTES);
    endfunction

    // expected result of one transaction, updating the local bank
    task automatic predict_bank_access(input logic [1:0] op,
                                       input logic [lmob_pkg::IDX_W-1:0] idx,
                                       input logic val, input logic [1:0] req,
                                       output led_result_t res);
        int  byte_sel;
        int  bit_sel;
        logic hit;
        res = '{led_state: 1'b0, status: lmob_pkg::STAT_DONE};
        hit = find_led(idx, byte_sel, bit_sel);
        unique case (op)
            lmob_pkg::CMD_GET:
                if (hit)
                    res.led_state = bank_copy[byte_sel][bit_sel];
                else
                    res.status = lmob_pkg::STAT_RANGE;
            lmob_pkg::CMD_SET:
                if (!hit)
                    res.status = lmob_pkg::STAT_RANGE;
                else if (mode_copy != lmob_pkg::MODE_NORMAL)
                    res.status = lmob_pkg::STAT_BLOCKED;
                else
                    bank_copy[byte_sel][bit_sel] = val;
            lmob_pkg::CMD_TEST:
                unique case (req)
                    lmob_pkg::REQ_NORMAL:
                        if (mode_copy != lmob_pkg::MODE_NORMAL)
                        begin
                            for (int i = 0; i < lmob_pkg::DEF_BANK_BYTES; i++)
                                bank_copy[i] = saved_copy[i];
                            mode_copy = lmob_pkg::MODE_NORMAL;
                        end
                    lmob_pkg::REQ_ALL_ON, lmob_pkg::REQ_ALL_OFF:
                    begin
                        // save only when leaving normal mode
                        for (int i = 0; i < lmob_pkg::DEF_BANK_BYTES; i++)
                        begin
                            if (mode_copy == lmob_pkg::MODE_NORMAL)
                                saved_copy[i] = bank_copy[i];
                            bank_copy[i] = (req == lmob_pkg::REQ_ALL_ON) ?
                                           lmob_pkg::FILL_ON : lmob_pkg::FILL_OFF;
                        end
                        mode_copy = lmob_pkg::mode_t'(req);
                    end
                    default: ;
                endcase
            default: ;
        endcase
    endtask

    // offer one transaction and record its expected result on acceptance
    task automatic send_item(input logic [1:0] op, input logic [lmob_pkg::IDX_W-1:0] idx,
                             input logic val, input logic [1:0] req);
        led_result_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid          = 1'b1;
        cmd               = op;
        led_index         = idx;
        led_value         = val;
        test_mode_request = req;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        predict_bank_access(op, idx, val, req, res);
        expected_results.push_back(res);
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only called while idle
    task automatic write_reg(input logic [lmob_pkg::CFG_IDX_W-1:0] addr,
                             input logic [lmob_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = addr;
        cfg_data  = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (addr == lmob_pkg::REG_ROWS)
            rows_copy = data[lmob_pkg::ROWS_W-1:0];
        else if (addr == lmob_pkg::REG_COLS)
            cols_copy = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random transaction, mostly well-formed accesses to existing leds
    task automatic send_random_item();
        logic [1:0]                 op;
        logic [1:0]                 req;
        logic [lmob_pkg::IDX_W-1:0] idx;
        int                         pick;
        int                         n;
        n    = led_count();
        pick = $urandom_range(0, 99);
        op   = (pick < 42) ? lmob_pkg::CMD_GET : (pick < 84) ? lmob_pkg::CMD_SET :
               (pick < 96) ? lmob_pkg::CMD_TEST : CMD_NONE;
        pick = $urandom_range(0, 99);
        req  = (pick < 55) ? lmob_pkg::REQ_NORMAL : (pick < 70) ? lmob_pkg::REQ_ALL_ON :
               (pick < 85) ? lmob_pkg::REQ_ALL_OFF : REQ_UNKNOWN;
        if (n > 0 && $urandom_range(0, 9) < 8)
            idx = lmob_pkg::IDX_W'($urandom_range(0, n - 1));
        else
            idx = lmob_pkg::IDX_W'($urandom_range(0, 255));
        send_item(op, idx, 1'($urandom_range(0, 1)), req);
    endtask

    // default geometry straight after reset
    task automatic test_reset_defaults();
        send_item(lmob_pkg::CMD_GET, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd95, 1'b1, lmob_pkg::REQ_ALL_ON);
        send_item(lmob_pkg::CMD_GET, 8'd96, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd255, 1'b1, REQ_UNKNOWN);
        send_item(lmob_pkg::CMD_SET, 8'd96, 1'b1, lmob_pkg::REQ_NORMAL);
    endtask

    // set and read back single bits
    task automatic test_set_get();
        send_item(lmob_pkg::CMD_SET, 8'd0, 1'b1, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_SET, 8'd95, 1'b1, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd95, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_SET, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
    endtask

    // lamp test entry, switch, blocking, restore and unknown codes
    task automatic test_lamp_test();
        send_item(lmob_pkg::CMD_SET, 8'd40, 1'b1, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_TEST, 8'd0, 1'b0, lmob_pkg::REQ_ALL_ON);
        send_item(lmob_pkg::CMD_GET, 8'd3, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_SET, 8'd3, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_SET, 8'd200, 1'b1, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_TEST, 8'd0, 1'b0, lmob_pkg::REQ_ALL_OFF);
        send_item(lmob_pkg::CMD_GET, 8'd40, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_TEST, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd40, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_TEST, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_TEST, 8'd0, 1'b0, REQ_UNKNOWN);
        send_item(CMD_NONE, 8'd255, 1'b1, REQ_UNKNOWN);
    endtask

    // zero, smallest, largest and oversized geometry
    task automatic test_config_extremes();
        wait_idle();
        write_reg(lmob_pkg::REG_ROWS, 5'd0);
        send_item(lmob_pkg::CMD_GET, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_SET, 8'd0, 1'b1, lmob_pkg::REQ_NORMAL);
        wait_idle();
        write_reg(lmob_pkg::REG_ROWS, 5'd31);
        write_reg(lmob_pkg::REG_COLS, 5'd31);
        send_item(lmob_pkg::CMD_SET, 8'd197, 1'b1, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd197, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd198, 1'b0, lmob_pkg::REQ_NORMAL);
        wait_idle();
        write_reg(lmob_pkg::REG_ROWS, 5'd1);
        write_reg(lmob_pkg::REG_COLS, 5'd1);
        send_item(lmob_pkg::CMD_GET, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        send_item(lmob_pkg::CMD_GET, 8'd1, 1'b0, lmob_pkg::REQ_NORMAL);
        wait_idle();
        write_reg(lmob_pkg::REG_COLS, 5'd0);
        write_reg(REG_NONE, 5'd31);
        send_item(lmob_pkg::CMD_GET, 8'd0, 1'b0, lmob_pkg::REQ_NORMAL);
        wait_idle();
        write_reg(lmob_pkg::REG_ROWS, lmob_pkg::CFG_DATA_W'(lmob_pkg::DEF_MAX_ROWS));
        write_reg(lmob_pkg::REG_COLS, lmob_pkg::CFG_DATA_W'(lmob_pkg::DEF_MAX_COLS));
    endtask

    // receiver holds off long enough to fill the block, then a full drain
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 80;
        repeat (12) send_random_item();
        wait_idle();
    endtask

    // random transactions with a fresh geometry every chunk
    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int items);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            wait_idle();
            if ($urandom_range(0, 9) == 0)
                write_reg(lmob_pkg::REG_ROWS,
                          lmob_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            else
                write_reg(lmob_pkg::REG_ROWS,
                          lmob_pkg::CFG_DATA_W'($urandom_range(1, lmob_pkg::DEF_MAX_ROWS)));
            if ($urandom_range(0, 9) == 0)
                write_reg(lmob_pkg::REG_COLS,
                          lmob_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            else
                write_reg(lmob_pkg::REG_COLS,
                          lmob_pkg::CFG_DATA_W'($urandom_range(1, lmob_pkg::DEF_MAX_COLS)));
            repeat (items / 4) send_random_item();
        end
    endtask

    // reset, test sequence and final verdict
    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        cmd               = lmob_pkg::CMD_GET;
        led_index         = '0;
        led_value         = 1'b0;
        test_mode_request = lmob_pkg::REQ_NORMAL;
        out_ready         = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = lmob_pkg::REG_ROWS;
        cfg_data          = '0;
        mismatch_count    = 0;
        cycle_count       = 0;
        tx_idle_pct       = 14;
        rx_idle_pct       = 52;
        rx_hold_left      = 0;
        rows_copy         = lmob_pkg::RESET_ROWS;
        cols_copy         = lmob_pkg::RESET_COLS;
        mode_copy         = lmob_pkg::MODE_NORMAL;
        for (int i = 0; i < lmob_pkg::DEF_BANK_BYTES; i++)
        begin
            bank_copy[i]  = 8'h00;
            saved_copy[i] = 8'h00;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_set_get();
        test_lamp_test();
        test_config_extremes();
        test_backpressure();
        test_random_phase(14, 52, 232);
        test_random_phase(52, 14, 232);
        test_random_phase(0, 0, 232);
        wait_idle();

        if (mismatch_count == 0)
            $display("led_matrix_onoff_bank_with_lamp_test_unit_tb passed");
        else
            $display("led_matrix_onoff_bank_with_lamp_test_unit_tb failed");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
src/lmob_pkg.sv
src/lmob_div.sv
src/lmob_ctrl.sv
src/lmob_dp.sv
src/led_matrix_onoff_bank_with_lamp_test_unit.sv
src/lmob_checker.sv
bench/led_matrix_onoff_bank_with_lamp_test_unit_tb.sv
